// ===== rtl/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
package b2da_pkg;

    localparam int VALUE_W         = 64;
    localparam int NUM_DIGITS      = 20;
    localparam int BCD_W           = 4 * NUM_DIGITS;
    localparam int CHAR_W          = 6;
    localparam int BIT_CNT_W       = $clog2(VALUE_W);
    localparam int DIG_CNT_W       = $clog2(NUM_DIGITS + 1);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);
    localparam logic [3:0]        BCD_FIVE   = 4'd5;
    localparam logic [3:0]        BCD_THREE  = 4'd3;

    typedef logic [BCD_W-1:0] bcd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/b2da_front.sv =====
// Front end: accepts a binary value and converts it to packed BCD by shift-add-3.
// Depends on b2da_pkg.
module b2da_front
    import b2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VALUE_W-1:0] value,
    input  q_stat_t            q_stat,
    output logic               q_push,
    output bcd_t               q_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_PUSH = 3'b100
    } front_state_t;

    front_state_t         state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    bcd_t                 bcd_reg, bcd_next;
    bcd_t                 bcd_adj;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= BCD_FIVE)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + BCD_THREE;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign full   = (state_reg != S_IDLE);
    assign q_push = (state_reg == S_PUSH) && !q_stat.full;
    assign q_data = bcd_reg;

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        value_next   = value_reg;
        bcd_next     = bcd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (push)
                begin
                    value_next   = value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], value_reg[VALUE_W-1]};
                value_next   = {value_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!q_stat.full)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        bcd_reg   <= bcd_next;
    end

endmodule

// ===== rtl/b2da_queue.sv =====
// Short queue of converted BCD words between front and back end.
// Depends on b2da_pkg.
module b2da_queue
    import b2da_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bcd_t    wr_data,
    input  logic    pop,
    output bcd_t    rd_data,
    output q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bcd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/b2da_back.sv =====
// Back end: walks a BCD word from the top digit, drops leading zeros, emits ASCII beats.
// Depends on b2da_pkg.
module b2da_back
    import b2da_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_stat_t           q_stat,
    input  bcd_t              q_data,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] digit_char,
    output logic              last_digit
);

    bcd_t                 bcd_reg, bcd_next;
    logic [DIG_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 leading_reg, leading_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic [3:0]           top;
    logic                 is_last, skip, slot_free;

    assign top       = bcd_reg[BCD_W-1 -: 4];
    assign is_last   = (cnt_reg == DIG_CNT_W'(1));
    assign skip      = leading_reg && (top == 4'd0) && !is_last;
    assign slot_free = !out_valid_reg || pop;
    assign q_pop     = !busy_reg && !q_stat.empty;

    assign empty      = !out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

    always_comb
    begin
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        leading_next   = leading_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (out_valid_reg && pop)
            out_valid_next = 1'b0;
        if (!busy_reg)
        begin
            if (!q_stat.empty)
            begin
                bcd_next     = q_data;
                cnt_next     = DIG_CNT_W'(NUM_DIGITS);
                busy_next    = 1'b1;
                leading_next = 1'b1;
            end
        end
        else if (skip)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
            cnt_next = cnt_reg - 1'b1;
        end
        else if (slot_free)
        begin
            out_valid_next = 1'b1;
            char_next      = ASCII_ZERO + CHAR_W'(top);
            last_next      = is_last;
            bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
            cnt_next       = cnt_reg - 1'b1;
            leading_next   = 1'b0;
            if (is_last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            leading_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            leading_reg   <= leading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DIG_CNT_W'(NUM_DIGITS))
        else $error("digit counter out of range");

    a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("busy with no digits left");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg >= ASCII_ZERO) && (char_reg <= ASCII_NINE))
        else $error("non-digit character emitted");

    a_more_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> busy_reg)
        else $error("number ended without a last digit");
`endif

endmodule

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_front, b2da_queue, b2da_back.
//
// Each pushed 64-bit unsigned value comes out as its decimal digits in ASCII,
// most significant first, one beat per digit, no leading zeros (zero gives a
// single '0'); the final digit has last_digit set. The front end accepts a value
// in S_IDLE, runs its shift-add-3 loop in S_CONV, one bit per cycle, and hands
// the result to the queue in S_PUSH, which waits while the queue is full. full
// stays high through S_CONV and S_PUSH, so the front end takes a new value only
// once the previous one is in the queue. The back end loads a word from the
// queue, then steps through every digit position, dropping leading zeros and
// emitting one digit per cycle while pop keeps up.
module binary_to_decimal_ascii_top
    import b2da_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VALUE_W-1:0] value,
    output logic               empty,
    input  logic               pop,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last_digit
);

    q_stat_t q_stat;
    logic    q_push, q_pop;
    bcd_t    q_wr_data, q_rd_data;

    b2da_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .value  (value),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    b2da_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    b2da_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

// ===== tb/binary_to_decimal_ascii_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for binary_to_decimal_ascii_top: pushes 64-bit values and
// checks every ASCII digit beat against a scoreboard that converts the same value.
// Depends on b2da_pkg and the converter RTL.
module binary_to_decimal_ascii_top_test;
    import b2da_pkg::*;

    localparam logic [VALUE_W-1:0] DEC_BASE = 10;
    localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = {VALUE_W{1'b1}};
    localparam int MAX_GAP      = 6;
    localparam int RANDOM_ITEMS = 250;
    localparam int PHASE_ITEMS  = 25;
    localparam int TAIL_CYCLES  = 100;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_beat_t;

    class digit_scoreboard;
        digit_beat_t pending_digits[$];
        int error_count    = 0;
        int values_noted   = 0;
        int digits_checked = 0;

        // Expand one accepted value into its digit beats, most significant first.
        function void note_value(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] rest;
            logic [3:0]         dec [NUM_DIGITS];
            int                 n;
            digit_beat_t        beat;
            rest = v;
            n = 0;
            do
            begin
                dec[n] = 4'(rest % DEC_BASE);
                rest = rest / DEC_BASE;
                n++;
            end
            while (rest != 0 && n < NUM_DIGITS);
            for (int k = n - 1; k >= 0; k--)
            begin
                beat.ch   = ASCII_ZERO + CHAR_W'(dec[k]);
                beat.last = (k == 0);
                pending_digits.push_back(beat);
            end
            values_noted++;
        endfunction

        function void check_digit(logic [CHAR_W-1:0] ch, logic last);
            digit_beat_t want;
            if (pending_digits.size() == 0)
            begin
                $display("%0t: unexpected digit beat, char %0d last_digit %0d",
                         $time, ch, last);
                error_count++;
                return;
            end
            want = pending_digits.pop_front();
            digits_checked++;
            if (ch !== want.ch)
            begin
                $display("%0t: digit_char mismatch, expected %0d, actual %0d",
                         $time, want.ch, ch);
                error_count++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_digit mismatch, expected %0d, actual %0d",
                         $time, want.last, last);
                error_count++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [VALUE_W-1:0] value;
    logic               empty;
    logic               pop;
    logic [CHAR_W-1:0]  digit_char;
    logic               last_digit;
    bit                 pop_eager;

    digit_scoreboard digits_sb = new();

    binary_to_decimal_ascii_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .empty      (empty),
        .pop        (pop),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int draw_gap(bit eager);
        return eager ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [VALUE_W-1:0] pow10(int k);
        logic [VALUE_W-1:0] p;
        p = 1;
        repeat (k) p = p * DEC_BASE;
        return p;
    endfunction

    // Mostly values of a random digit count, some raw 64-bit, some decade edges.
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] raw;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] span;
        int                 n;
        int                 pick;
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return raw;
        n  = $urandom_range(1, NUM_DIGITS);
        lo = (n == 1) ? '0 : pow10(n - 1);
        if (pick == 2)
            return $urandom_range(0, 1) ? lo : lo - 1;
        span = (n == NUM_DIGITS) ? VALUE_ALL_ONES - lo + 1 : pow10(n) - lo;
        return lo + raw % span;
    endfunction

    task automatic send_value(logic [VALUE_W-1:0] v, bit eager);
        int gap;
        gap = draw_gap(eager);
        if (gap != 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push  = 1'b1;
        value = v;
        do @(posedge clk); while (full !== 1'b0);
        digits_sb.note_value(v);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (digits_sb.pending_digits.size() != 0) @(negedge clk);
    endtask

    // Result side
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(pop_eager);
            if (gap != 0)
            begin
                pop = 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop = 1'b1;
            do @(posedge clk); while (empty !== 1'b0);
            digits_sb.check_digit(digit_char, last_digit);
            @(negedge clk);
        end
    end

    // Watchdog on cycles without any beat
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((push && full === 1'b0) || (pop && empty === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [VALUE_W-1:0] corner_vals[$];
        bit                 send_eager;
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        value     = '0;
        pop_eager = 1'b0;
        corner_vals = '{
            64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd1234567890,
            64'd4294967295, 64'd4294967296, 64'h8000_0000_0000_0000,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'd9999999999999999999, 64'd10000000000000000000,
            64'd12345678901234567890, 64'd18446744073709551615
        };
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_eager = 1'b0;
        foreach (corner_vals[i])
            send_value(corner_vals[i], send_eager);
        push = 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_ITEMS == 0)
            begin
                send_eager = ($urandom_range(0, 3) == 0);
                pop_eager  = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_ITEMS / 2)
            begin
                push = 1'b0;
                wait_drained();
            end
            send_value(rand_value(), send_eager);
        end
        push = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (digits_sb.pending_digits.size() != 0)
        begin
            $display("%0t: %0d digit beats never arrived",
                     $time, digits_sb.pending_digits.size());
            digits_sb.error_count++;
        end
        $display("Converted %0d values (decade edges, 1 to 20 digits, full range),",
                 digits_sb.values_noted);
        $display("checked %0d digit beats under random push and pop gaps.",
                 digits_sb.digits_checked);
        if (digits_sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
